### design/iuhsf_pkg.sv
// Package for the IPv4/UDP header strip filter.
// Holds the transaction payload types and the fixed protocol constants.
// No dependencies.
package iuhsf_pkg;

   localparam int unsigned BYTE_WIDTH   = 8;
   localparam int unsigned QUEUE_WIDTH  = 6;
   localparam int unsigned PLEN_WIDTH   = 14;
   localparam int unsigned ADDR_WIDTH   = 32;
   localparam int unsigned ETYPE_WIDTH  = 16;
   localparam int unsigned WORDS_WIDTH  = 4;
   localparam int unsigned HDR_WIDTH    = 7;

   localparam logic [ADDR_WIDTH-1:0]  MATCH_ADDR_RESET = 32'hC0A8_0180;
   localparam logic [ETYPE_WIDTH-1:0] ETHERTYPE_IPV4   = 16'h0800;

   localparam int unsigned ETH_LEN        = 14;
   localparam int unsigned UDP_LEN        = 8;
   localparam int unsigned MIN_IP_WORDS   = 5;
   localparam int unsigned MIN_FRAME_LEN  = 34;
   localparam int unsigned LEN_CAP        = 16383;

   // Byte offsets of the captured header fields.
   localparam int unsigned OFF_ETYPE_HI   = 12;
   localparam int unsigned OFF_ETYPE_LO   = 13;
   localparam int unsigned OFF_IHL        = 14;
   localparam int unsigned OFF_SRC_FIRST  = 26;
   localparam int unsigned OFF_SRC_LAST   = 29;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0]  byte_value;
      logic                   end_of_packet;
      logic [QUEUE_WIDTH-1:0] rx_queue;
   } req_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0]  byte_out;
      logic                   in_payload;
      logic                   frame_end;
      logic                   verdict;
      logic [QUEUE_WIDTH-1:0] queue_index;
      logic [PLEN_WIDTH-1:0]  payload_length;
   } rsp_type;

endpackage

### design/iuhsf_frame_parser.sv
// Per-frame header capture and verdict logic of the header strip filter.
// Holds the frame state and forms one result from the staged byte.
// Depends on iuhsf_pkg.
module iuhsf_frame_parser
   import iuhsf_pkg::*;
#(
   parameter int unsigned MAX_FRAME_BYTES = 16383,
   parameter int unsigned QUEUE_COUNT     = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  req_type               item,
   input  logic [ADDR_WIDTH-1:0] match_addr,
   output rsp_type               result
);

   localparam int unsigned OFFSET_WIDTH = $clog2(MAX_FRAME_BYTES + 1);
   localparam int unsigned LEN_WIDTH    = OFFSET_WIDTH + 1;

   logic [OFFSET_WIDTH-1:0] offset_ff, offset_in;
   logic [ETYPE_WIDTH-1:0]  etype_ff, etype_in;
   logic [WORDS_WIDTH-1:0]  words_ff, words_in;
   logic [ADDR_WIDTH-1:0]   src_ff, src_in;
   logic [QUEUE_WIDTH-1:0]  queue_ff, queue_in;

   logic [HDR_WIDTH-1:0]    hdr_len;
   logic [LEN_WIDTH-1:0]    frame_len;
   logic [LEN_WIDTH-1:0]    len_diff;
   logic                    len_ok;
   logic                    accept_frame;
   logic                    last;

   assign last = item.end_of_packet;

   // Fields captured by the current byte take effect for this same byte.
   always_comb begin
      queue_in = (offset_ff == '0) ? item.rx_queue : queue_ff;
      etype_in = etype_ff;
      if (offset_ff == OFFSET_WIDTH'(OFF_ETYPE_HI)
          || offset_ff == OFFSET_WIDTH'(OFF_ETYPE_LO)) begin
         etype_in = {etype_ff[ETYPE_WIDTH-BYTE_WIDTH-1:0], item.byte_value};
      end
      words_in = (offset_ff == OFFSET_WIDTH'(OFF_IHL)) ? item.byte_value[WORDS_WIDTH-1:0]
                                                       : words_ff;
      src_in = src_ff;
      if (offset_ff >= OFFSET_WIDTH'(OFF_SRC_FIRST)
          && offset_ff <= OFFSET_WIDTH'(OFF_SRC_LAST)) begin
         src_in = {src_ff[ADDR_WIDTH-BYTE_WIDTH-1:0], item.byte_value};
      end
      if (offset_ff < OFFSET_WIDTH'(MAX_FRAME_BYTES)) begin
         offset_in = offset_ff + OFFSET_WIDTH'(1);
      end else begin
         offset_in = offset_ff;
      end
   end

   assign hdr_len   = HDR_WIDTH'(ETH_LEN + UDP_LEN) + {1'b0, words_in, 2'b00};
   assign frame_len = {1'b0, offset_ff} + LEN_WIDTH'(1);
   assign len_ok    = frame_len >= LEN_WIDTH'(hdr_len);
   assign len_diff  = frame_len - LEN_WIDTH'(hdr_len);

   assign accept_frame = (etype_in == ETHERTYPE_IPV4)
                      && (frame_len >= LEN_WIDTH'(MIN_FRAME_LEN))
                      && (src_in == match_addr)
                      && (words_in >= WORDS_WIDTH'(MIN_IP_WORDS))
                      && len_ok
                      && ({1'b0, queue_in} < (QUEUE_WIDTH + 1)'(QUEUE_COUNT));

   always_comb begin
      result                = '0;
      result.byte_out       = item.byte_value;
      result.in_payload     = offset_ff >= OFFSET_WIDTH'(hdr_len);
      result.frame_end      = last;
      if (last) begin
         result.verdict     = accept_frame;
         result.queue_index = queue_in;
         if (len_ok) begin
            if (32'(len_diff) > 32'(LEN_CAP)) begin
               result.payload_length = PLEN_WIDTH'(LEN_CAP);
            end else begin
               result.payload_length = PLEN_WIDTH'(32'(len_diff));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         etype_ff  <= '0;
         words_ff  <= '0;
         src_ff    <= '0;
         queue_ff  <= '0;
      end else if (advance) begin
         if (last) begin
            offset_ff <= '0;
            etype_ff  <= '0;
            words_ff  <= '0;
            src_ff    <= '0;
            queue_ff  <= '0;
         end else begin
            offset_ff <= offset_in;
            etype_ff  <= etype_in;
            words_ff  <= words_in;
            src_ff    <= src_in;
            queue_ff  <= queue_in;
         end
      end
   end

endmodule

### design/ipv4_udp_header_strip_filter_core.sv
// Top level of the IPv4/UDP header strip filter.
// Instantiates iuhsf_frame_parser; depends on iuhsf_pkg.
//
// Frame bytes enter one per transaction with a last-byte mark and the receive
// queue. Each byte is echoed with a payload mark once it lies past the
// Ethernet, IPv4 and UDP headers; on the last byte the result also carries the
// verdict (redirect when the frame is IPv4 from the match address, reset to
// MATCH_ADDR_RESET and set by csr_write_data, with complete headers and a
// queue below QUEUE_COUNT), the queue index and the saturated payload length.
// While the result side is not stalled the block takes one byte per cycle:
// each transaction is latched in an input register, judged by the parser
// logic against the running frame state and latched in the result register
// when that is free. While the result side stalls, input is still accepted until both registers are full.
module ipv4_udp_header_strip_filter_core
   import iuhsf_pkg::*;
#(
   parameter int unsigned MAX_FRAME_BYTES = 16383,
   parameter int unsigned QUEUE_COUNT     = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  csr_write_enable,
   input  logic [ADDR_WIDTH-1:0] csr_write_data
);

   logic [ADDR_WIDTH-1:0] match_addr_ff;
   req_type               stage_item_ff;
   logic                  stage_valid_ff;
   rsp_type               rsp_ff;
   logic                  rsp_valid_ff;
   rsp_type               parse_result;
   logic                  out_open;
   logic                  advance;

   assign out_open  = !rsp_valid_ff || rsp_ready;
   assign advance   = stage_valid_ff && out_open;
   assign req_ready = !stage_valid_ff || advance;

   iuhsf_frame_parser #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
      .QUEUE_COUNT    (QUEUE_COUNT)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (stage_item_ff),
      .match_addr(match_addr_ff),
      .result    (parse_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         match_addr_ff <= MATCH_ADDR_RESET;
      end else if (csr_write_enable) begin
         match_addr_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stage_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         stage_item_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_open) begin
         rsp_valid_ff <= stage_valid_ff;
      end
      if (advance) begin
         rsp_ff <= parse_result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
